FILE: sv/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
// No dependencies; imported by sitda_dabble and signed_int_to_decimal_ascii.
`timescale 1ns / 1ps

package sitda_pkg;

  // Width of the value field on the port, and the width actually converted.
  localparam int unsigned IN_WIDTH    = 64;
  localparam int unsigned VALUE_WIDTH = 64;

  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
  localparam int unsigned NUM_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_WIDTH   = 4 * NUM_DIGITS;

  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int unsigned DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam int unsigned CHAR_WIDTH  = 6;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

  // Operation applied to the shift datapath in one cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_DIGIT
  } dab_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_e;

endpackage

FILE: sv/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per strobe.
// Depends on sitda_pkg and sitda_dabble.
`timescale 1ns / 1ps

//  channel   ports                          transaction
//  -------   ----------------------------   ------------------------------------------
//  command   start_i, busy_o, value_i       taken at an edge with start_i=1, busy_o=0
//  result    valid_o, character_o,          one character per valid_o cycle, always
//            is_last_o                      taken at the edge that ends that cycle
//
// busy_o stays high after a command is taken, through the shift-and-add-3 loop,
// one input bit per cycle, a state that shows the minus sign when the value is
// negative, the digit shift register, one decimal digit per cycle for skipped
// zeros and output, and a step that finds the first digit to show.
// Reset clears the sequencer and the result strobe; the datapath needs none.
// The receiver cannot stall: each character shows for exactly one cycle.
// busy_o falls in the cycle that shows the last character, so the next command
// may be taken at the edge that ends that cycle.

module signed_int_to_decimal_ascii (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [sitda_pkg::IN_WIDTH-1:0]    value_i,
  output logic                              valid_o,
  output logic [sitda_pkg::CHAR_WIDTH-1:0]  character_o,
  output logic                              is_last_o
);
  import sitda_pkg::*;

  state_e                 state_q, state_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic                   neg_q, neg_d;
  logic                   valid_q, valid_d;
  logic [CHAR_WIDTH-1:0]  char_q, char_d;
  logic                   last_q, last_d;
  dab_op_e                op;
  logic [3:0]             top_digit;
  logic                   lead_zero;

  sitda_dabble u_dabble (
    .clk_i       (clk_i),
    .op_i        (op),
    .raw_i       (value_i[VALUE_WIDTH-1:0]),
    .top_digit_o (top_digit)
  );

  // A leading zero is dropped unless it is the only digit left.
  assign lead_zero = (top_digit == 4'd0) && (dig_cnt_q > DIG_CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == '0) begin
          state_d = neg_q ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!lead_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (dig_cnt_q == DIG_CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control, counters and the result register.
  always_comb begin
    op        = OP_HOLD;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    neg_d     = neg_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op        = OP_LOAD;
          neg_d     = value_i[VALUE_WIDTH-1];
          bit_cnt_d = BIT_CNT_W'(VALUE_WIDTH - 1);
        end
      end
      ST_CONV: begin
        op        = OP_DABBLE;
        bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
        dig_cnt_d = DIG_CNT_W'(NUM_DIGITS);
      end
      ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = CHAR_MINUS;
      end
      ST_SKIP: begin
        // Drop leading zeros one digit a cycle.
        if (lead_zero) begin
          op        = OP_DIGIT;
          dig_cnt_d = dig_cnt_q - DIG_CNT_W'(1);
        end
      end
      ST_EMIT: begin
        op        = OP_DIGIT;
        valid_d   = 1'b1;
        char_d    = CHAR_ZERO + {2'b00, top_digit};
        last_d    = (dig_cnt_q == DIG_CNT_W'(1));
        dig_cnt_d = dig_cnt_q - DIG_CNT_W'(1);
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
      neg_q     <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      neg_q     <= neg_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  // Character payload holds without reset.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign is_last_o   = last_q;

`ifndef ASSERT_OFF
  // A character only follows a cycle in which a command was in progress.
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("character strobed without a command in progress");

  // A taken command keeps the block busy and silent while it converts.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !valid_o)
    else $error("accepted command did not start conversion");

  // The last character releases the block in the same cycle.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_last_o |-> !busy_o)
    else $error("block still busy after the last character");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (character_o == CHAR_MINUS) |-> !is_last_o)
    else $error("minus sign flagged as last character");
`endif

endmodule

FILE: sv/sitda_dabble.sv
// Bit-serial binary to BCD shift datapath (shift-and-add-3), plus digit shift-out.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_dabble (
  input  logic                                clk_i,
  input  sitda_pkg::dab_op_e                  op_i,
  input  logic [sitda_pkg::VALUE_WIDTH-1:0]   raw_i,
  output logic [3:0]                          top_digit_o
);
  import sitda_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d;
  logic [BCD_WIDTH-1:0]   adj;
  logic [VALUE_WIDTH-1:0] mag;

  // Two's complement magnitude; the most negative value wraps to 2^(W-1).
  always_comb begin
    if (raw_i[VALUE_WIDTH-1]) begin
      mag = (~raw_i) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      mag = raw_i;
    end
  end

  // Add 3 to every digit of five or more before the next doubling.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    case (op_i)
      OP_LOAD: begin
        bin_d = mag;
        bcd_d = '0;
      end
      OP_DABBLE: begin
        bcd_d = {adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      end
      OP_DIGIT: begin
        bcd_d = {bcd_q[BCD_WIDTH-5:0], 4'b0000};
      end
      default: begin
        bin_d = bin_q;
        bcd_d = bcd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BCD_WIDTH-1 -: 4];

endmodule
